@@ design/ipv6tt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6tt_pkg
// Types, character codes and helper functions shared by the IPv6
// address-to-text unit.
// ----------------------------------------------------------------------------
package ipv6tt_pkg;

    localparam int NUM_GROUPS = 8;   // 16-bit groups in an address
    localparam int NUM_BYTES  = 16;  // bytes in an address
    localparam int NUM_DEC    = 4;   // bytes written in dotted-decimal form
    localparam int TOK_CHARS  = 5;   // longest text piece: four digits and a separator
    localparam int COMP_MIN_RUN = 4; // shortest zero run that is compressed

    typedef logic [6:0] char_t;

    localparam char_t CH_COLON = 7'h3A;
    localparam char_t CH_DOT   = 7'h2E;
    localparam char_t CH_ZERO  = 7'h30;
    localparam char_t CH_LOWER_A = 7'h61;

    // One hex group, digits left-justified, without leading zeros.
    typedef struct packed {
        char_t [3:0] ch;
        logic  [2:0] cnt;
    } hex_grp_t;

    // One decimal byte, digits left-justified, without leading zeros.
    typedef struct packed {
        char_t [2:0] ch;
        logic  [1:0] cnt;
    } dec_byte_t;

    // One piece of the output text; len of zero means the piece is skipped.
    typedef struct packed {
        char_t [TOK_CHARS-1:0] ch;
        logic  [2:0]           len;
    } token_t;

    // Whole text of one address as a row of pieces.
    typedef struct packed {
        token_t [NUM_GROUPS-1:0] tok;
        logic   [NUM_GROUPS-1:0] used;
        logic   [2:0]            last_tok;
    } text_plan_t;

    // Lower-case hex digit for one nibble.
    function automatic char_t hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return CH_ZERO + 7'(nib);
        else
            return CH_LOWER_A + 7'(nib - 4'd10);
    endfunction

    // Decimal digit for a value from 0 to 9.
    function automatic char_t dec_char(input logic [3:0] dig);
        return CH_ZERO + 7'(dig);
    endfunction

endpackage
`default_nettype wire

@@ design/ipv6tt_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6tt_if
// Valid/ready channels of the IPv6 address-to-text unit: the address
// channel and the character channel.
// ----------------------------------------------------------------------------
interface ipv6tt_addr_if;
    logic        valid;
    logic        ready;
    logic [63:0] addr_high;
    logic [63:0] addr_low;

    modport source (output valid, output addr_high, output addr_low, input ready);
    modport sink   (input valid, input addr_high, input addr_low, output ready);
endinterface

interface ipv6tt_text_if;
    logic       valid;
    logic       ready;
    logic [6:0] text_char;
    logic       last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface
`default_nettype wire

@@ design/ipv6_address_to_text_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6_address_to_text_unit
// Converts a 128-bit IPv6 address to its text form with zero-run
// compression and the dotted-decimal form for compatible addresses, one
// ASCII character per transaction.
// ----------------------------------------------------------------------------
//
//  Channel  Role    Payload                   Transaction
//  -------  ------  ------------------------  ---------------------------
//  addr     sink    addr_high, addr_low       one address
//  text     source  text_char, last_char      one character of the text
//
//  An address is registered in merge stage A, then in merge stage B, then
//  its text leaves at one character per cycle while text is ready. Its text
//  of 2 to 39 characters, through the single character port, sets its pace.
//  The next address is taken while the current text is still being sent,
//  and its text follows the final character with no idle cycle.
//  A stall on text holds the current character; addr backs up once both
//  merge stages are full.
//  Reset clears all valid flags at once; no memory needs clearing.
//
module ipv6_address_to_text_unit
    import ipv6tt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    ipv6tt_addr_if.sink          addr,
    ipv6tt_text_if.source        text
);

    logic [127:0]                addr_all;
    hex_grp_t [NUM_GROUPS-1:0]   grp_fmt;
    dec_byte_t [NUM_DEC-1:0]     dec_fmt;
    logic [NUM_BYTES-1:0]        zero_mask;
    logic                        dotted;

    logic                        plan_valid;
    logic                        plan_ready;
    text_plan_t                  plan;

    assign addr_all = {addr.addr_high, addr.addr_low};

    // First twelve bytes zero and byte 12 or 13 nonzero: dotted-decimal form.
    assign dotted = (addr_all[127:32] == 96'd0) && (addr_all[31:16] != 16'd0);

    // One hex lane per group.
    for (genvar g = 0; g < NUM_GROUPS; g++)
    begin : g_hex
        ipv6tt_hex_lane u_hex_lane (
            .grp       (addr_all[127-16*g -: 16]),
            .fmt       (grp_fmt[g]),
            .zero_byte ({zero_mask[2*g], zero_mask[2*g+1]})
        );
    end

    // One decimal lane per byte of the last four.
    for (genvar d = 0; d < NUM_DEC; d++)
    begin : g_dec
        ipv6tt_dec_lane u_dec_lane (
            .value (addr_all[8*(NUM_DEC-d)-1 -: 8]),
            .fmt   (dec_fmt[d])
        );
    end

    // Run search and text layout.
    ipv6tt_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (addr.valid),
        .in_ready  (addr.ready),
        .grp_fmt   (grp_fmt),
        .dec_fmt   (dec_fmt),
        .zero_mask (zero_mask),
        .dotted    (dotted),
        .out_valid (plan_valid),
        .out_ready (plan_ready),
        .plan      (plan)
    );

    // Character output.
    ipv6tt_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (plan_valid),
        .in_ready  (plan_ready),
        .plan      (plan),
        .out_valid (text.valid),
        .out_ready (text.ready),
        .text_char (text.text_char),
        .last_char (text.last_char)
    );

`ifndef NO_ASSERTIONS
    // A text is never cut short: after a character that is not the final one,
    // another follows.
    a_text_continues: assert property (@(posedge clk) disable iff (!rst_n)
        text.valid && text.ready && !text.last_char |=> text.valid)
        else $error("text ended before its final character");

    // A finished layout waiting on the serializer stays put.
    a_plan_held: assert property (@(posedge clk) disable iff (!rst_n)
        plan_valid && !plan_ready |=> plan_valid && $stable(plan))
        else $error("layout changed while waiting for the serializer");

    // Dots only separate decimal bytes, so a text never ends in one.
    a_no_trailing_dot: assert property (@(posedge clk) disable iff (!rst_n)
        text.valid && (text.text_char == CH_DOT) |-> !text.last_char)
        else $error("text ends in a dot");
`endif

endmodule
`default_nettype wire

@@ design/ipv6tt_hex_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6tt_hex_lane
// Formats one 16-bit group as lower-case hex without leading zeros and
// flags which of its two bytes are zero.
// ----------------------------------------------------------------------------
module ipv6tt_hex_lane
    import ipv6tt_pkg::*;
(
    input  logic [15:0] grp,
    output hex_grp_t    fmt,
    output logic [1:0]  zero_byte  // [1] upper byte, [0] lower byte
);

    logic [2:0]  cnt;
    logic [1:0]  lead;
    logic [15:0] aligned;

    // Digit count from the first nonzero nibble; a zero group keeps one digit.
    always_comb
    begin
        if (grp[15:12] != 4'd0)
            cnt = 3'd4;
        else if (grp[11:8] != 4'd0)
            cnt = 3'd3;
        else if (grp[7:4] != 4'd0)
            cnt = 3'd2;
        else
            cnt = 3'd1;
    end

    assign lead    = 2'(3'd4 - cnt);
    assign aligned = grp << {lead, 2'b00};

    // Left-justify the significant digits.
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            fmt.ch[j] = hex_char(aligned[15-4*j -: 4]);
        end
        fmt.cnt = cnt;
    end

    assign zero_byte[1] = (grp[15:8] == 8'd0);
    assign zero_byte[0] = (grp[7:0] == 8'd0);

endmodule
`default_nettype wire

@@ design/ipv6tt_dec_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6tt_dec_lane
// Formats one byte as decimal without leading zeros. Quotients come from
// reciprocal multiplies that are exact over the byte range.
// ----------------------------------------------------------------------------
module ipv6tt_dec_lane
    import ipv6tt_pkg::*;
(
    input  logic [7:0] value,
    output dec_byte_t  fmt
);

    logic [13:0] prod100;
    logic [15:0] prod10;
    logic [1:0]  q100;
    logic [4:0]  q10;
    logic [7:0]  q10_x10;
    logic [4:0]  q100_x10;
    logic [3:0]  hund;
    logic [3:0]  tens;
    logic [3:0]  ones;

    // value / 100 = (value * 41) >> 12 and value / 10 = (value * 205) >> 11.
    assign prod100  = 14'(value) * 14'd41;
    assign prod10   = 16'(value) * 16'd205;
    assign q100     = prod100[13:12];
    assign q10      = prod10[15:11];
    assign q10_x10  = 8'({q10, 3'b000}) + 8'({q10, 1'b0});
    assign q100_x10 = 5'({q100, 3'b000}) + 5'({q100, 1'b0});
    assign hund     = {2'b00, q100};
    assign tens     = 4'(q10 - q100_x10);
    assign ones     = 4'(value - q10_x10);

    // Left-justify the significant digits.
    always_comb
    begin
        if (value >= 8'd100)
        begin
            fmt.cnt   = 2'd3;
            fmt.ch[0] = dec_char(hund);
            fmt.ch[1] = dec_char(tens);
            fmt.ch[2] = dec_char(ones);
        end
        else if (value >= 8'd10)
        begin
            fmt.cnt   = 2'd2;
            fmt.ch[0] = dec_char(tens);
            fmt.ch[1] = dec_char(ones);
            fmt.ch[2] = dec_char(ones);
        end
        else
        begin
            fmt.cnt   = 2'd1;
            fmt.ch[0] = dec_char(ones);
            fmt.ch[1] = dec_char(ones);
            fmt.ch[2] = dec_char(ones);
        end
    end

endmodule
`default_nettype wire

@@ design/ipv6tt_merge.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6tt_merge
// Combines the lane results into the text of one address. Stage A holds the
// lane outputs and each byte's zero-run length; stage B picks the first longest
// run and lays out one piece per group, or "::" and four decimal bytes.
// ----------------------------------------------------------------------------
module ipv6tt_merge
    import ipv6tt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  hex_grp_t [NUM_GROUPS-1:0] grp_fmt,
    input  dec_byte_t [NUM_DEC-1:0]  dec_fmt,
    input  logic [NUM_BYTES-1:0]     zero_mask,  // bit i set when byte i is zero
    input  logic                     dotted,
    output logic                     out_valid,
    input  logic                     out_ready,
    output text_plan_t               plan
);

    typedef struct packed {
        logic [3:0] idx;
        logic [4:0] len;
    } cand_t;

    logic [4:0]  run_len [NUM_BYTES];

    logic                      a_valid_reg, a_valid_next;
    hex_grp_t [NUM_GROUPS-1:0] grp_reg;
    dec_byte_t [NUM_DEC-1:0]   dec_reg;
    logic [4:0]                run_reg [NUM_BYTES];
    logic                      dotted_reg;
    logic                      a_ready;

    logic       b_valid_reg, b_valid_next;
    text_plan_t plan_reg, plan_next;
    logic       b_ready;

    cand_t l1 [8];
    cand_t l2 [4];
    cand_t l3 [2];
    cand_t best;

    logic       comp;
    logic [3:0] run_last;
    logic [3:0] gs;
    logic [3:0] ge;

    // Zero-run length starting at each byte: distance to the next nonzero byte.
    always_comb
    begin
        for (int i = 0; i < NUM_BYTES; i++)
        begin
            run_len[i] = 5'(NUM_BYTES - i);
            for (int j = NUM_BYTES - 1; j >= i; j--)
            begin
                if (!zero_mask[j])
                    run_len[i] = 5'(j - i);
            end
        end
    end

    // Stage A handshake.
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (a_ready)
            a_valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= a_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            grp_reg    <= grp_fmt;
            dec_reg    <= dec_fmt;
            run_reg    <= run_len;
            dotted_reg <= dotted;
        end
    end

    // First longest run: a registered-input tree, the lower index wins ties.
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            if (run_reg[2*k] >= run_reg[2*k+1])
                l1[k] = '{idx: 4'(2*k), len: run_reg[2*k]};
            else
                l1[k] = '{idx: 4'(2*k+1), len: run_reg[2*k+1]};
        end
        for (int k = 0; k < 4; k++)
        begin
            l2[k] = (l1[2*k].len >= l1[2*k+1].len) ? l1[2*k] : l1[2*k+1];
        end
        for (int k = 0; k < 2; k++)
        begin
            l3[k] = (l2[2*k].len >= l2[2*k+1].len) ? l2[2*k] : l2[2*k+1];
        end
        best = (l3[0].len >= l3[1].len) ? l3[0] : l3[1];
    end

    // Compressed groups run from gs (start rounded up to even) through ge.
    assign comp     = (best.len >= 5'(COMP_MIN_RUN));
    assign run_last = 4'(5'(best.idx) + best.len - 5'd1);
    assign gs       = 4'((5'(best.idx) + 5'd1) >> 1);
    assign ge       = run_last[0] ? {1'b0, run_last[3:1]}
                                  : ({1'b0, run_last[3:1]} - 4'd1);

    // Lay out the text: one piece per group, or "::" and four decimal bytes.
    always_comb
    begin
        plan_next = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            if (dotted_reg)
            begin
                if (g == 0)
                begin
                    plan_next.tok[g].ch  = {TOK_CHARS{CH_COLON}};
                    plan_next.tok[g].len = 3'd2;
                end
                else if (g <= NUM_DEC)
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        plan_next.tok[g].ch[j] = (j < int'(dec_reg[2'(g - 1)].cnt))
                                                 ? dec_reg[2'(g - 1)].ch[j] : CH_DOT;
                    end
                    plan_next.tok[g].ch[3] = CH_DOT;
                    plan_next.tok[g].ch[4] = CH_DOT;
                    plan_next.tok[g].len   = 3'(dec_reg[2'(g - 1)].cnt)
                                             + ((g != NUM_DEC) ? 3'd1 : 3'd0);
                end
            end
            else if (comp && 4'(g) == gs)
            begin
                plan_next.tok[g].ch  = {TOK_CHARS{CH_COLON}};
                plan_next.tok[g].len = (gs == 4'd0) ? 3'd2 : 3'd1;
            end
            else if (comp && 4'(g) > gs && 4'(g) <= ge)
            begin
                plan_next.tok[g].ch  = {TOK_CHARS{CH_COLON}};
                plan_next.tok[g].len = 3'd0;
            end
            else
            begin
                for (int j = 0; j < 4; j++)
                begin
                    plan_next.tok[g].ch[j] = (j < int'(grp_reg[g].cnt))
                                             ? grp_reg[g].ch[j] : CH_COLON;
                end
                plan_next.tok[g].ch[4] = CH_COLON;
                plan_next.tok[g].len   = grp_reg[g].cnt
                                         + ((g != NUM_GROUPS - 1) ? 3'd1 : 3'd0);
            end
            plan_next.used[g] = (plan_next.tok[g].len != 3'd0);
        end
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            if (plan_next.used[g])
                plan_next.last_tok = 3'(g);
        end
    end

    // Stage B handshake.
    assign b_ready = !b_valid_reg || out_ready;

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (b_ready)
            b_valid_next = a_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= b_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (a_valid_reg && b_ready)
            plan_reg <= plan_next;
    end

    assign out_valid = b_valid_reg;
    assign plan      = plan_reg;

endmodule
`default_nettype wire

@@ design/ipv6tt_serializer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6tt_serializer
// Holds the text of one address and sends it one character per
// transaction, skipping empty pieces. The next text loads in the cycle
// that the final character is taken.
// ----------------------------------------------------------------------------
module ipv6tt_serializer
    import ipv6tt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  text_plan_t plan,
    output logic       out_valid,
    input  logic       out_ready,
    output char_t      text_char,
    output logic       last_char
);

    logic       valid_reg, valid_next;
    logic [2:0] tok_reg, tok_next;
    logic [2:0] chr_reg, chr_next;
    text_plan_t plan_reg;

    token_t     cur_tok;
    logic       end_of_tok;
    logic       is_last;
    logic [2:0] next_tok;
    logic       fire;
    logic       load;

    assign cur_tok    = plan_reg.tok[tok_reg];
    assign end_of_tok = ((4'(chr_reg) + 4'd1) == 4'(cur_tok.len));
    assign is_last    = end_of_tok && (tok_reg == plan_reg.last_tok);

    // Next nonempty piece after the current one.
    always_comb
    begin
        next_tok = tok_reg;
        for (int g = NUM_GROUPS - 1; g >= 0; g--)
        begin
            if (plan_reg.used[g] && (3'(g) > tok_reg))
                next_tok = 3'(g);
        end
    end

    assign fire     = valid_reg && out_ready;
    assign in_ready = !valid_reg || (fire && is_last);
    assign load     = in_valid && in_ready;

    // Character position update.
    always_comb
    begin
        valid_next = valid_reg;
        tok_next   = tok_reg;
        chr_next   = chr_reg;
        if (load)
        begin
            valid_next = 1'b1;
            tok_next   = 3'd0;
            chr_next   = 3'd0;
        end
        else if (fire && is_last)
        begin
            valid_next = 1'b0;
        end
        else if (fire)
        begin
            if (end_of_tok)
            begin
                tok_next = next_tok;
                chr_next = 3'd0;
            end
            else
            begin
                chr_next = chr_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= 3'd0;
            chr_reg   <= 3'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
            chr_reg   <= chr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            plan_reg <= plan;
    end

    assign out_valid = valid_reg;
    assign text_char = cur_tok.ch[chr_reg];
    assign last_char = is_last;

endmodule
`default_nettype wire

@@ tb/ipv6_address_to_text_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6_address_to_text_unit_test
// Self-checking bench for the IPv6 address-to-text unit. Every accepted
// address is turned into its expected character stream by a behavioral
// formatter in this file. Each character that leaves the unit is compared
// with the oldest expected one. Directed corner addresses come first, then
// shaped random addresses, then a burst with no idle cycles. Random address
// gaps and text stalls run everywhere but in the no-idle stretches.
// ----------------------------------------------------------------------------
module ipv6_address_to_text_unit_test;
    import ipv6tt_pkg::*;

    localparam int RANDOM_ITEMS = 240;
    localparam int BURST_ITEMS  = 40;
    localparam int TAIL_CYCLES  = 50;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int MAX_REPORTS  = 40;

    // One expected character of the text stream.
    typedef struct packed {
        char_t ch;
        logic  last;
    } text_beat_t;

    logic clk;
    logic rst_n;

    ipv6tt_addr_if addr_ch ();
    ipv6tt_text_if text_ch ();

    ipv6_address_to_text_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .addr  (addr_ch),
        .text  (text_ch)
    );

    text_beat_t expected_text [$];
    text_beat_t want_beat;
    string      hex_digits = "0123456789abcdef";

    int  error_count      = 0;
    int  address_count    = 0;
    int  char_count       = 0;
    int  dotted_count     = 0;
    int  compressed_count = 0;
    int  cycle_count      = 0;
    int  ready_stall      = 0;
    bit  no_idle          = 0;

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard limit on the length of the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d characters still expected", $time,
                     expected_text.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Formats one address into its text and appends the characters to the
    // expected stream, flagging the final one.
    function automatic void format_address_text(input logic [63:0] hi, input logic [63:0] lo);
        logic [7:0]  b [16];
        logic [15:0] grp;
        logic [3:0]  nib;
        logic [7:0]  v;
        char_t       line [$];
        text_beat_t  beat;
        int          i, j, k, n;
        int          run_start, run_last, run_len;
        bit          lead_zero, lead, done;

        for (i = 0; i < 8; i++)
        begin
            b[i]     = hi[63 - 8 * i -: 8];
            b[i + 8] = lo[63 - 8 * i -: 8];
        end
        lead_zero = 1'b1;
        for (i = 0; i < 12; i++)
            if (b[i] != 8'd0) lead_zero = 1'b0;

        if (lead_zero && (b[12] != 8'd0 || b[13] != 8'd0))
        begin
            // Compatible form: "::" and the last four bytes in decimal.
            dotted_count++;
            line.push_back(CH_COLON);
            line.push_back(CH_COLON);
            for (i = 12; i < 16; i++)
            begin
                v = b[i];
                if (v >= 8'd100) line.push_back(CH_ZERO + 7'(v / 8'd100));
                if (v >= 8'd10)  line.push_back(CH_ZERO + 7'((v / 8'd10) % 8'd10));
                line.push_back(CH_ZERO + 7'(v % 8'd10));
                if (i != 15) line.push_back(CH_DOT);
            end
        end
        else
        begin
            // Find the first longest run of zero bytes.
            run_start = 0;
            run_last  = 0;
            run_len   = 0;
            for (i = 0; i < 16; i++)
            begin
                j = i;
                while (j < 16 && b[j] == 8'd0) j++;
                if (j - i > run_len)
                begin
                    run_start = i;
                    run_last  = j - 1;
                    run_len   = j - i;
                end
            end
            if (run_start % 2 == 1) run_start++;
            if (run_len >= COMP_MIN_RUN) compressed_count++;

            k = 0;
            done = 1'b0;
            while (k < 16 && !done)
            begin
                if (run_len >= COMP_MIN_RUN && k == run_start)
                begin
                    if (run_start == 0) line.push_back(CH_COLON);
                    k = run_last;
                    line.push_back(CH_COLON);
                    if (k == 15)
                        done = 1'b1;
                    else if (k % 2 == 1)
                        k++;
                end
                if (!done)
                begin
                    // One group in hex without leading zeros.
                    grp  = {b[k], b[k + 1]};
                    lead = 1'b1;
                    for (n = 3; n >= 0; n--)
                    begin
                        nib = grp[4 * n +: 4];
                        if (nib != 4'd0 || !lead || n == 0)
                        begin
                            line.push_back(char_t'(hex_digits[nib]));
                            lead = 1'b0;
                        end
                    end
                    if (k != 14) line.push_back(CH_COLON);
                    k += 2;
                end
            end
        end

        for (i = 0; i < line.size(); i++)
        begin
            beat.ch   = line[i];
            beat.last = (i == line.size() - 1);
            expected_text.push_back(beat);
        end
    endfunction

    // Drives one address with a random lead-in gap and waits for the
    // transaction; valid stays high afterwards for a possible next address.
    task automatic send_address(input logic [63:0] hi, input logic [63:0] lo);
        int gap;

        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            addr_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        addr_ch.valid     <= 1'b1;
        addr_ch.addr_high <= hi;
        addr_ch.addr_low  <= lo;
        do
            @(posedge clk);
        while (!addr_ch.ready);
        format_address_text(hi, lo);
        address_count++;
    endtask

    // Holds off the address side until every expected character has come.
    task automatic wait_for_text_drain();
        addr_ch.valid <= 1'b0;
        while (expected_text.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Builds a random address shaped to hit zero runs, short groups and
    // the dotted-decimal form.
    task automatic make_random_address(output logic [63:0] hi, output logic [63:0] lo);
        logic [7:0] b [16];
        int         mode, i, p, len, runs, r;

        mode = $urandom_range(0, 99);
        for (i = 0; i < 16; i++) b[i] = 8'($urandom_range(0, 255));

        if (mode < 10)
        begin
            // Fully random bytes.
        end
        else if (mode < 35)
        begin
            // Bytes that are often zero or have a zero nibble.
            for (i = 0; i < 16; i++)
            begin
                r = $urandom_range(0, 3);
                if (r == 0)
                    b[i] = 8'd0;
                else if (r == 1)
                    b[i] = 8'($urandom_range(0, 15));
                else if (r == 2)
                    b[i] = 8'($urandom_range(0, 15) << 4);
            end
        end
        else if (mode < 70)
        begin
            // One or two zero runs at random places.
            runs = $urandom_range(1, 2);
            repeat (runs)
            begin
                p   = $urandom_range(0, 15);
                len = $urandom_range(1, 16 - p);
                for (i = p; i < p + len; i++) b[i] = 8'd0;
            end
        end
        else if (mode < 85)
        begin
            // Leading twelve bytes zero, last four sometimes zero.
            for (i = 0; i < 12; i++) b[i] = 8'd0;
            for (i = 12; i < 16; i++)
                if ($urandom_range(0, 3) == 0) b[i] = 8'd0;
        end
        else
        begin
            // Mostly zero with a few nonzero bytes.
            for (i = 0; i < 16; i++) b[i] = 8'd0;
            runs = $urandom_range(1, 3);
            repeat (runs) b[$urandom_range(0, 15)] = 8'($urandom_range(1, 255));
        end

        for (i = 0; i < 8; i++)
        begin
            hi[63 - 8 * i -: 8] = b[i];
            lo[63 - 8 * i -: 8] = b[i + 8];
        end
    endtask

    // Corner addresses: extremes, both text forms and each run rule.
    task automatic test_corner_addresses();
        send_address(64'h0, 64'h0);
        send_address(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
        send_address(64'h0, 64'h1);
        send_address(64'h0, 64'h0000_0000_c0a8_0001);
        send_address(64'h0, 64'h0000_0000_0a00_0000);
        send_address(64'h0, 64'h0000_0000_00ff_6409);
        send_address(64'h0, 64'h0000_0000_ffff_ffff);
        send_address(64'h0, 64'h0000_ffff_c0a8_0001);
        send_address(64'h0, 64'h0000_0001_c0a8_0001);
        send_address(64'h0, 64'h0000_0000_0000_ff00);
        send_address(64'h2001_0db8_0000_0000, 64'h0);
        send_address(64'h0100_0000_0000_0000, 64'h0);
        // Zero runs of three bytes are left alone.
        send_address(64'h0001_0000_0001_0000, 64'h0001_0000_0001_0000);
        send_address(64'h0000_0012_3456_789a, 64'h1111_2222_3333_4444);
        // Two equal runs: the first one is compressed.
        send_address(64'h1111_0000_0000_2222, 64'h3333_0000_0000_4444);
        // Odd run start with even and odd run end.
        send_address(64'h1100_0000_0011_2233, 64'h4455_6677_8899_aabb);
        send_address(64'h1200_0000_0000_3456, 64'h789a_bcde_f012_3456);
        // Run that reaches the last byte from an odd start.
        send_address(64'h1234_5678_9abc_def0, 64'h1200_0000_0000_0000);
        send_address(64'hffff_ffff_ffff_ffff, 64'h1111_2222_0000_0000);
        send_address(64'habcd_0000_0000_ef01, 64'h2345_6789_abcd_ef01);
        // Groups with every count of leading zeros.
        send_address(64'h0001_0010_0100_1000, 64'h000f_00f0_0f00_f000);
        send_address(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
    endtask

    // Shaped random addresses with stretches of no idling on both sides.
    task automatic test_random_mixed();
        logic [63:0] hi, lo;
        int          i;

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_idle = ((i / 40) % 4 == 3);
            make_random_address(hi, lo);
            send_address(hi, lo);
            if (i == RANDOM_ITEMS / 2) wait_for_text_drain();
        end
        no_idle = 1'b0;
    endtask

    // Addresses back to back with the text side always ready.
    task automatic test_back_to_back();
        logic [63:0] hi, lo;

        no_idle = 1'b1;
        repeat (BURST_ITEMS)
        begin
            make_random_address(hi, lo);
            send_address(hi, lo);
        end
        no_idle = 1'b0;
    endtask

    // Text side: random stalls and a check of every character transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (text_ch.valid && text_ch.ready)
            begin
                char_count++;
                if (expected_text.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: unexpected character expected none actual 0x%02h last %0b",
                                 $time, text_ch.text_char, text_ch.last_char);
                end
                else
                begin
                    want_beat = expected_text.pop_front();
                    if (text_ch.text_char !== want_beat.ch)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t: text_char mismatch expected 0x%02h actual 0x%02h",
                                     $time, want_beat.ch, text_ch.text_char);
                    end
                    if (text_ch.last_char !== want_beat.last)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t: last_char mismatch expected %0b actual %0b",
                                     $time, want_beat.last, text_ch.last_char);
                    end
                end
                ready_stall = no_idle ? 0 : $urandom_range(0, 3);
                if (ready_stall > 0) text_ch.ready <= 1'b0;
            end
            else if (!text_ch.ready)
            begin
                if (ready_stall <= 1)
                begin
                    ready_stall = 0;
                    text_ch.ready <= 1'b1;
                end
                else
                    ready_stall--;
            end
        end
        else
            text_ch.ready <= 1'b0;
    end

    // Test sequence.
    initial
    begin
        addr_ch.valid     <= 1'b0;
        addr_ch.addr_high <= 64'h0;
        addr_ch.addr_low  <= 64'h0;
        rst_n             <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_addresses();
        wait_for_text_drain();
        test_random_mixed();
        wait_for_text_drain();
        test_back_to_back();
        wait_for_text_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Converted %0d addresses into %0d checked characters.", address_count,
                 char_count);
        $display("Of these, %0d used the dotted-decimal form and %0d a compressed zero run.",
                 dotted_count, compressed_count);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
